FILE: hw/rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants
// Sample, configuration and result records, fixed-point constants and the
// register indexes of the domain transform coefficient block.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int OUT_W  = 32;
  localparam int ROOT_W = 32;   // root of a 64-bit radicand
  localparam int QUOT_W = 32;   // quotient of the normalizing divide

  localparam logic [OUT_W-1:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [OUT_W-1:0] SAT32        = 32'hFFFF_FFFF;
  localparam logic [OUT_W-1:0] RATIO_RESET  = 32'h0001_0000;

  // register indexes of the configuration port
  localparam logic REG_FILTER_MODE = 1'b0;
  localparam logic REG_RATIO       = 1'b1;

  // filter modes
  localparam logic MODE_DISTANCE  = 1'b0;
  localparam logic MODE_CURVATURE = 1'b1;

  typedef struct packed {
    logic [3:0][NRM_W-1:0] nrm;   // x at [0] .. w at [3]
    logic [2:0][POS_W-1:0] pos;   // x at [0] .. z at [2]
  } sample_t;

  typedef struct packed {
    logic             mode;
    logic [OUT_W-1:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] raw;
    logic [OUT_W-1:0] coef;
  } result_t;

endpackage

FILE: hw/rtl/dtc_sqrt.sv
// ----------------------------------------------------------------------------
// dtc_sqrt: iterative integer square root
// Floor root of a 64-bit radicand, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module dtc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                radicand,
  output logic                       done,
  output logic [dtc_pkg::ROOT_W-1:0] root
);
  import dtc_pkg::*;

  logic [63:0]       x;
  logic [33:0]       rem;
  logic [4:0]        step;
  logic              run;
  logic [35:0]       rem_s;
  logic [35:0]       trial;

  // one restoring digit step
  assign rem_s = {rem, x[63:62]};
  assign trial = {2'b00, root, 2'b01};

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 5'd1;
        if (step == 5'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      x <= {x[61:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= 34'(rem_s - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s[33:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/dtc_div.sv
// ----------------------------------------------------------------------------
// dtc_div: iterative restoring divider
// 64-bit dividend over 32-bit divisor, one quotient bit per cycle. The
// quotient must fit 32 bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
module dtc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                num,
  input  logic [31:0]                den,
  output logic                       done,
  output logic [dtc_pkg::QUOT_W-1:0] quot
);
  import dtc_pkg::*;

  logic [31:0] rem;
  logic [31:0] low;
  logic [31:0] dsr;
  logic [4:0]  step;
  logic        run;
  logic [32:0] rem_s;

  assign rem_s = {rem, low[31]};

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 5'd1;
        if (step == 5'(QUOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[63:32];
      low  <= num[31:0];
      dsr  <= den;
      quot <= '0;
    end else if (run) begin
      low <= {low[30:0], 1'b0};
      if (rem_s >= {1'b0, dsr}) begin
        rem  <= 32'(rem_s - {1'b0, dsr});
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s[31:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/dtc_core.sv
// ----------------------------------------------------------------------------
// dtc_core: sequencer and shared datapath
// Holds the previous sample, sums the distance term or runs the curvature term
// via one shared multiplier, the root unit and divider; forms the coefficient.
// ----------------------------------------------------------------------------
module dtc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtc_pkg::sample_t  in_sample,
  input  logic              in_seed,
  input  dtc_pkg::cfg_t     cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output dtc_pkg::result_t  res
);
  import dtc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_POS  = 10'b00_0000_0010,
    S_SQ   = 10'b00_0000_0100,
    S_LEN  = 10'b00_0000_1000,
    S_DIV  = 10'b00_0001_0000,
    S_DIFF = 10'b00_0010_0000,
    S_ROOT = 10'b00_0100_0000,
    S_MUL  = 10'b00_1000_0000,
    S_COEF = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t            state;
  logic [2:0]        cnt;
  logic              vec_b;     // 0: current normal, 1: previous normal
  logic              div_go;
  sample_t           cur;
  sample_t           prev;
  logic [63:0]       acc;
  logic [63:0]       prod;
  logic [31:0]       len;
  logic [3:0][31:0]  ua;
  logic [3:0][31:0]  ub;
  logic [31:0]       raw;
  logic [31:0]       coef;

  logic [1:0]        idx;
  logic [15:0]       nrm_sel;
  logic [15:0]       nrm_mag;
  logic [32:0]       pos_diff;
  logic [32:0]       pos_mag;
  logic [63:0]       pos_sum;
  logic [32:0]       u_diff;
  logic [31:0]       u_mag;
  logic [63:0]       acc_sum;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [48:0]       coef_sum;
  logic [31:0]       u_val;

  logic              sq_start;
  logic [63:0]       sq_in;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  // operand selection
  assign idx      = cnt[1:0];
  assign nrm_sel  = vec_b ? prev.nrm[idx] : cur.nrm[idx];
  assign nrm_mag  = nrm_sel[15] ? 16'(-nrm_sel) : nrm_sel;
  assign pos_diff = {cur.pos[idx][31], cur.pos[idx]} - {prev.pos[idx][31], prev.pos[idx]};
  assign pos_mag  = pos_diff[32] ? 33'(-pos_diff) : pos_diff;
  assign pos_sum  = acc + {31'd0, pos_mag};
  assign u_diff   = {ua[idx][31], ua[idx]} - {ub[idx][31], ub[idx]};
  assign u_mag    = u_diff[32] ? 32'(-u_diff) : u_diff[31:0];
  assign acc_sum  = acc + prod;
  assign coef_sum = {1'b0, prod[63:16]} + {17'd0, ONE_Q16};
  assign u_val    = nrm_sel[15] ? 32'(-{1'b0, div_quot[30:0]}) : {1'b0, div_quot[30:0]};

  // shared multiplier operands
  always_comb begin
    case (state)
      S_SQ: begin
        mul_a = {16'd0, nrm_mag};
        mul_b = {16'd0, nrm_mag};
      end
      S_DIFF: begin
        mul_a = u_mag;
        mul_b = u_mag;
      end
      S_MUL: begin
        mul_a = cfg.ratio;
        mul_b = raw;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // unit launches
  assign sq_start  = (state == S_SQ && cnt == 3'd4 && acc_sum != 64'd0) ||
                     (state == S_DIFF && cnt == 3'd4);
  assign sq_in     = (state == S_SQ) ? {1'b0, acc_sum[32:0], 30'd0} : acc_sum;
  assign div_start = (state == S_DIV) && div_go;

  dtc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  dtc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({3'd0, nrm_mag, 45'd0}),
    .den   (len),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.raw   = raw;
  assign res.coef  = coef;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      vec_b  <= 1'b0;
      div_go <= 1'b0;
      prev   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt   <= '0;
          vec_b <= 1'b0;
          if (in_valid) begin
            if (in_seed) begin
              prev <= in_sample;
            end else if (cfg.mode == MODE_CURVATURE) begin
              state <= S_SQ;
            end else begin
              state <= S_POS;
            end
          end
        end
        S_POS: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) begin
            state <= S_MUL;
          end
        end
        S_SQ: begin
          if (cnt == 3'd4) begin
            cnt <= '0;
            if (acc_sum != 64'd0) begin
              state <= S_LEN;
            end else if (vec_b) begin
              state <= S_DIFF;
            end else begin
              vec_b <= 1'b1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_LEN: begin
          if (sq_done) begin
            state  <= S_DIV;
            div_go <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (cnt == 3'd3) begin
              cnt    <= '0;
              div_go <= 1'b0;
              if (vec_b) begin
                state <= S_DIFF;
              end else begin
                vec_b <= 1'b1;
                state <= S_SQ;
              end
            end else begin
              cnt    <= cnt + 3'd1;
              div_go <= 1'b1;
            end
          end else begin
            div_go <= 1'b0;
          end
        end
        S_DIFF: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_COEF;
        end
        S_COEF: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            prev  <= cur;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        cur <= in_sample;
        acc <= '0;
      end
      S_POS: begin
        acc <= pos_sum;
        if (cnt == 3'd2) begin
          raw <= (pos_sum > {32'd0, SAT32}) ? SAT32 : pos_sum[31:0];
        end
      end
      S_SQ: begin
        if (cnt == 3'd4) begin
          acc <= '0;
          if (acc_sum == 64'd0) begin
            if (vec_b) begin
              ub <= '0;
            end else begin
              ua <= '0;
            end
          end
        end else if (cnt != 3'd0) begin
          acc <= acc_sum;
        end
      end
      S_LEN: begin
        if (sq_done) begin
          len <= sq_root;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (vec_b) begin
            ub[idx] <= u_val;
          end else begin
            ua[idx] <= u_val;
          end
        end
      end
      S_DIFF: begin
        if (cnt != 3'd0) begin
          acc <= acc_sum;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          raw <= {14'd0, sq_root[31:14]};
        end
      end
      S_COEF: begin
        coef <= (coef_sum > {17'd0, SAT32}) ? SAT32 : coef_sum[31:0];
      end
      default: begin
      end
    endcase
  end

  // checks
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_sq_done_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_LEN || state == S_ROOT))
    else $error("root unit finished outside a root phase");

  a_curv_raw_narrow: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && sq_done) |=> (raw[31:18] == 14'd0))
    else $error("curvature term wider than 18 bits");

  a_seed_no_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_seed) |=> (state == S_IDLE))
    else $error("seed beat started a computation");

endmodule

FILE: hw/rtl/domain_transform_coefficient.sv
// ----------------------------------------------------------------------------
// domain_transform_coefficient: edge-aware domain transform coefficient
// Per surface sample, 1 + ratio * d against the previous sample, where d is
// the position L1 distance or the length of the normalized normal difference.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one surface sample per beat; tuser set marks a seed beat
//   that only loads the previous sample and produces no result.
//   m_axis carries one result per non-seed sample: coefficient and raw term.
//   cfg_we/cfg_index/cfg_data write filter_mode (index 0) and ratio (index 1);
//   write them only while the block is idle.
// Sequence:
//   Seed beat: loads the previous sample in idle; the next beat may follow at once.
//   Distance mode: sums the position term, multiplies it by ratio and forms
//   the coefficient; the next beat is taken once the result is in the output register.
//   Curvature mode: normalizes the current and the previous normal through
//   the root unit and the divider, takes the root of their squared difference
//   and forms the coefficient; an all-zero normal skips its root and divide.
//   s_axis_tready stays low while an item is in work.
// Reset: synchronous, clears the previous sample to zero, filter_mode to 0 and
//   ratio to 1.0.
// Stall: a result waits in the output register; the core holds its next
//   result until that register drains.
// ----------------------------------------------------------------------------
module domain_transform_coefficient (
  input  logic         clk,
  input  logic         rst,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, nrm_w
  input  logic         s_axis_tuser,  // seed_only
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // coefficient, raw_difference
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import dtc_pkg::*;

  cfg_t    cfg;
  sample_t in_sample;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  // unpack the input beat
  assign in_sample.pos[0] = s_axis_tdata[31:0];
  assign in_sample.pos[1] = s_axis_tdata[63:32];
  assign in_sample.pos[2] = s_axis_tdata[95:64];
  assign in_sample.nrm[0] = s_axis_tdata[111:96];
  assign in_sample.nrm[1] = s_axis_tdata[127:112];
  assign in_sample.nrm[2] = s_axis_tdata[143:128];
  assign in_sample.nrm[3] = s_axis_tdata[159:144];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_DISTANCE;
      cfg.ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE: cfg.mode  <= cfg_data[0];
        REG_RATIO:       cfg.ratio <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (in_sample),
    .in_seed   (s_axis_tuser),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {res.raw, res.coef};
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: domain transform coefficient testbench
// A directed part and a random part drive surface samples through the stream
// slave side, with gaps on both sides. The bench carries its own model of the
// coefficient math and the previous sample, and checks each result beat field
// by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import dtc_pkg::*;

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [159:0]  s_axis_tdata;   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, nrm_w
  logic          s_axis_tuser;   // seed_only
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [63:0]   m_axis_tdata;   // coefficient, raw_difference
  logic          cfg_we;
  logic          cfg_index;
  logic [31:0]   cfg_data;

  domain_transform_coefficient u_top (.*);

  // model state and configuration
  logic                  mdl_mode;
  logic [31:0]           mdl_ratio;
  logic [2:0][31:0]      mdl_prev_pos;
  logic [3:0][15:0]      mdl_prev_nrm;

  result_t               coef_queue[$];
  int                    mismatches;
  bit                    quiet;        // no idling on either side
  int                    ready_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL domain_transform_coefficient");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q2.14 normal to Q1.30 unit vector; zero normal stays zero
  function automatic void unit_normal(input logic [3:0][15:0] c,
                                      output longint u[4]);
    logic [63:0] mag[4];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = $signed(c[k]) < 0 ? 64'(-longint'($signed(c[k])))
                                 : 64'(longint'($signed(c[k])));
      sum += mag[k] * mag[k];
    end
    for (int k = 0; k < 4; k++) u[k] = 0;
    if (sum == 0) return;
    len = int_root(sum << 30);
    for (int k = 0; k < 4; k++) begin
      q = (mag[k] << 45) / len;
      u[k] = $signed(c[k]) < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // expected result of one sample; updates the previous sample
  function automatic void predict_coefficient(input sample_t smp, input logic seed,
                                              output bit has_result,
                                              output result_t res);
    logic [63:0] d;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] m;
    longint      diff;
    longint      ua[4];
    longint      ub[4];
    d = '0;
    res = '0;
    if (!seed) begin
      if (mdl_mode == MODE_DISTANCE) begin
        for (int k = 0; k < 3; k++) begin
          diff = longint'($signed(smp.pos[k])) - longint'($signed(mdl_prev_pos[k]));
          d += diff < 0 ? 64'(-diff) : 64'(diff);
        end
      end else begin
        unit_normal(smp.nrm, ua);
        unit_normal(mdl_prev_nrm, ub);
        q = '0;
        for (int k = 0; k < 4; k++) begin
          diff = ua[k] - ub[k];
          m = diff < 0 ? 64'(-diff) : 64'(diff);
          q += m * m;
        end
        d = int_root(q) >> 14;
      end
      if (d > 64'(SAT32)) d = 64'(SAT32);
      prod = ((64'(mdl_ratio) * d) >> 16) + 64'(ONE_Q16);
      if (prod > 64'(SAT32)) prod = 64'(SAT32);
      res.coef = prod[31:0];
      res.raw  = d[31:0];
    end
    mdl_prev_pos = smp.pos;
    mdl_prev_nrm = smp.nrm;
    has_result = !seed;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_stall   <= 0;
    end else if (ready_stall > 0 && !quiet) begin
      m_axis_tready <= 1'b0;
      ready_stall   <= ready_stall - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      ready_stall   <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
      ready_stall   <= 0;
    end
  end

  // result beat check
  always @(posedge clk) begin
    result_t exp_res;
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (coef_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat coef=%h raw=%h", got.coef, got.raw);
      end else begin
        exp_res = coef_queue.pop_front();
        if (got.coef !== exp_res.coef || got.raw !== exp_res.raw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: coef exp %h got %h, raw exp %h got %h",
                     exp_res.coef, got.coef, exp_res.raw, got.raw);
        end
      end
    end
  end

  // send one sample beat and record its expectation on accept
  task automatic send_sample(input sample_t smp, input logic seed);
    int      gap;
    bit      has_result;
    result_t res;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= seed;
    do @(posedge clk); while (!s_axis_tready);
    predict_coefficient(smp, seed, has_result, res);
    if (has_result) coef_queue.push_back(res);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (coef_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FILTER_MODE) mdl_mode = val[0];
    else mdl_ratio = val;
  endtask

  function automatic sample_t make_sample(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [15:0] nx,
                                          logic [15:0] ny, logic [15:0] nz,
                                          logic [15:0] nw);
    sample_t s;
    s.pos[0] = px; s.pos[1] = py; s.pos[2] = pz;
    s.nrm[0] = nx; s.nrm[1] = ny; s.nrm[2] = nz; s.nrm[3] = nw;
    return s;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2:    return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
    endcase
  endfunction

  function automatic logic [15:0] rand_nrm();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1:       return 16'h0000;
      2:       return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    for (int k = 0; k < 3; k++) s.pos[k] = rand_pos();
    if ($urandom_range(0, 9) == 0) s.nrm = '0;
    else for (int k = 0; k < 4; k++) s.nrm[k] = rand_nrm();
    return s;
  endfunction

  // distance mode edges: reset previous, saturation, seeds, ratio extremes
  task automatic test_distance();
    send_sample(make_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0, '0, '0, '0, '0), 1'b0);
    send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0);
    send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
    send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            '0, '0, '0, '0), 1'b0);
    send_sample(make_sample(32'h1234_5678, 32'h0, 32'h0, '0, '0, '0, '0), 1'b1);
    send_sample(make_sample(32'h1234_5679, 32'h0, 32'h0, '0, '0, '0, '0), 1'b0);
    write_reg(REG_RATIO, 32'hFFFF_FFFF);
    send_sample(make_sample(32'h0, 32'h0, 32'h0, '0, '0, '0, '0), 1'b0);
    send_sample(make_sample(32'h0, 32'h0, 32'h0, '0, '0, '0, '0), 1'b0);
    send_sample(make_sample(32'h0000_0001, 32'h0, 32'h0, '0, '0, '0, '0), 1'b0);
    write_reg(REG_RATIO, 32'h0);
    send_sample(make_sample(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, '0, '0, '0, '0), 1'b0);
  endtask

  // curvature mode edges: zero normals, opposite and extreme normals, seeds
  task automatic test_curvature();
    write_reg(REG_FILTER_MODE, 32'(MODE_CURVATURE));
    write_reg(REG_RATIO, 32'h0002_8000);
    send_sample(make_sample('0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'h4000, '0, '0, '0), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'hC000, '0, '0, '0), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'h0001, '0, '0, '0), 1'b0);
    send_sample(make_sample('0, '0, '0, '0, 16'hFFFF, '0, '0), 1'b1);
    send_sample(make_sample('0, '0, '0, '0, '0, 16'h2D41, 16'h2D41), 1'b0);
    send_sample(make_sample('0, '0, '0, '0, '0, '0, '0), 1'b0);
    write_reg(REG_RATIO, 32'hFFFF_FFFF);
    send_sample(make_sample('0, '0, '0, 16'h7FFF, '0, '0, '0), 1'b0);
    send_sample(make_sample('0, '0, '0, 16'h8000, '0, '0, '0), 1'b0);
  endtask

  // random phases over mode and ratio settings
  task automatic test_random();
    logic [31:0] r;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_FILTER_MODE, 32'(phase[0]));
      case (phase)
        0:       r = 32'h0;
        1:       r = 32'hFFFF_FFFF;
        2:       r = RATIO_RESET;
        default: r = $urandom();
      endcase
      write_reg(REG_RATIO, r);
      quiet = (phase == 4);
      for (int n = 0; n < 180; n++) begin
        if (phase == 3 && n == 90) wait_drain();
        send_sample(rand_sample(), $urandom_range(0, 9) == 0);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_FILTER_MODE;
    cfg_data      = '0;
    mdl_mode      = MODE_DISTANCE;
    mdl_ratio     = RATIO_RESET;
    mdl_prev_pos  = '0;
    mdl_prev_nrm  = '0;
    mismatches    = 0;
    quiet         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_distance();
    test_curvature();
    test_random();

    wait_drain();
    if (mismatches == 0 && coef_queue.size() == 0) begin
      $display("PASS domain_transform_coefficient");
    end else begin
      $display("FAIL domain_transform_coefficient");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_sqrt.sv
hw/rtl/dtc_div.sv
hw/rtl/dtc_core.sv
hw/rtl/domain_transform_coefficient.sv
dv/tb_top.sv
